// ===== hdl/dtgl_pkg.sv =====
`timescale 1ns / 1ps

package dtgl_pkg;

  localparam int CODE_W   = 8;
  localparam int OX_W     = 10;
  localparam int OY_W     = 9;
  localparam int PEN_X_W  = 12;
  localparam int PEN_Y_W  = 11;
  localparam int GX_W     = 11;
  localparam int GY_W     = 10;
  localparam int TU_W     = 7;
  localparam int TV_W     = 5;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 10;

  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_HEIGHT = 3'd3;

  localparam logic [OX_W-1:0] RST_ORIGIN_X   = 10'd0;
  localparam logic [OY_W-1:0] RST_ORIGIN_Y   = 9'd0;
  localparam logic [OX_W-1:0] RST_BOX_WIDTH  = 10'd256;
  localparam logic [OY_W-1:0] RST_BOX_HEIGHT = 9'd200;

  localparam logic [CODE_W-1:0] CH_TAB     = 8'd9;
  localparam logic [CODE_W-1:0] CH_NL      = 8'd10;
  localparam logic [CODE_W-1:0] CH_SPACE   = 8'd32;
  localparam logic [CODE_W-1:0] CH_GLYPH_HI = 8'd95;
  localparam logic [CODE_W-1:0] CH_LOWER_A = 8'd97;
  localparam logic [CODE_W-1:0] CH_LOWER_Z = 8'd122;
  localparam logic [CODE_W-1:0] CASE_OFS   = 8'd32;

  localparam logic [PEN_X_W-1:0] ADV_CHAR = 12'd8;
  localparam logic [PEN_X_W-1:0] ADV_TAB  = 12'd32;
  localparam logic [PEN_Y_W-1:0] ADV_LINE = 11'd8;

  typedef struct packed {
    logic [OX_W-1:0] origin_x;
    logic [OY_W-1:0] origin_y;
    logic [OX_W-1:0] box_width;
    logic [OY_W-1:0] box_height;
  } cfg_t;

  typedef struct packed {
    logic [PEN_X_W-1:0] pen_x;
    logic [PEN_Y_W-1:0] pen_y;
    logic               halted;
  } pen_t;

  typedef struct packed {
    logic            emit;
    logic [GX_W-1:0] glyph_x;
    logic [GY_W-1:0] glyph_y;
    logic [TU_W-1:0] tex_u;
    logic [TV_W-1:0] tex_v;
  } glyph_t;

endpackage

// ===== hdl/dtgl_layout.sv =====
`timescale 1ns / 1ps

module dtgl_layout (
  input  dtgl_pkg::cfg_t             cfg,
  input  dtgl_pkg::pen_t             pen,
  input  logic [dtgl_pkg::CODE_W-1:0] char_code,
  output dtgl_pkg::pen_t             pen_nxt,
  output dtgl_pkg::glyph_t           glyph
);
  import dtgl_pkg::*;

  logic [CODE_W-1:0]  c;
  logic [CODE_W-1:0]  g;
  logic               is_glyph;
  logic [PEN_X_W-1:0] x_end;
  logic [PEN_Y_W-1:0] y_end;
  logic [PEN_X_W-1:0] px1;
  logic [PEN_Y_W-1:0] py1;
  logic [PEN_X_W-1:0] px2;
  logic [PEN_Y_W-1:0] py2;

  always_comb begin
    x_end = PEN_X_W'(cfg.origin_x) + PEN_X_W'(cfg.box_width);
    y_end = PEN_Y_W'(cfg.origin_y) + PEN_Y_W'(cfg.box_height);

    if (char_code >= CH_LOWER_A && char_code <= CH_LOWER_Z) begin
      c = char_code - CASE_OFS;
    end else begin
      c = char_code;
    end
    g = c - CASE_OFS;
    is_glyph = (c > CH_SPACE) && (c <= CH_GLYPH_HI);

    px1 = pen.pen_x;
    py1 = pen.pen_y;
    if (c == CH_SPACE || is_glyph) begin
      px1 = pen.pen_x + ADV_CHAR;
    end else if (c == CH_TAB) begin
      px1 = pen.pen_x + ADV_TAB;
    end else if (c == CH_NL) begin
      px1 = PEN_X_W'(cfg.origin_x);
      py1 = pen.pen_y + ADV_LINE;
    end

    if (px1 >= x_end) begin
      px2 = PEN_X_W'(cfg.origin_x);
      py2 = py1 + ADV_LINE;
    end else begin
      px2 = px1;
      py2 = py1;
    end

    if (pen.halted) begin
      pen_nxt = pen;
    end else begin
      pen_nxt.pen_x  = px2;
      pen_nxt.pen_y  = py2;
      pen_nxt.halted = (py2 >= y_end);
    end

    glyph.emit    = is_glyph && !pen.halted;
    glyph.glyph_x = pen.pen_x[GX_W-1:0];
    glyph.glyph_y = pen.pen_y[GY_W-1:0];
    glyph.tex_u   = {g[3:0], 3'b000};
    glyph.tex_v   = {g[5:4], 3'b000};
  end

endmodule

// ===== hdl/debug_text_glyph_layout_top.sv =====
`timescale 1ns / 1ps

// channel | direction | request
// in_     | in        | char_code, last_char
// out_    | out       | glyph_x, glyph_y, tex_u, tex_v (printable codes only)
// cfg_    | in        | cfg_index, cfg_data (origin_x, origin_y, box_width, box_height)
//
// One character per cycle while in_ready is high; pen update and glyph lookup finish in the cycle of
// acceptance and the result is in the output register from the next cycle on.
// A full output register that is not taken stalls in_ready; it reopens in the
// same cycle out_ready rises. cfg_ready is always high; a write to one of the four registers restarts the pen.
// Reset (rst_n low, synchronous) loads default box and clears pen and output valid.

module debug_text_glyph_layout_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [dtgl_pkg::CODE_W-1:0]   in_char_code,
  input  logic                          in_last_char,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [dtgl_pkg::GX_W-1:0]     out_glyph_x,
  output logic [dtgl_pkg::GY_W-1:0]     out_glyph_y,
  output logic [dtgl_pkg::TU_W-1:0]     out_tex_u,
  output logic [dtgl_pkg::TV_W-1:0]     out_tex_v,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [dtgl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dtgl_pkg::CFG_DAT_W-1:0] cfg_data
);
  import dtgl_pkg::*;

  cfg_t   cfg_r, cfg_nxt;
  pen_t   pen_r, pen_nxt, pen_step;
  glyph_t glyph;
  glyph_t res_r;
  logic   out_valid_r, out_valid_nxt;
  logic   in_fire;
  logic   cfg_fire;
  logic   cfg_hit;

  dtgl_layout u_layout (
    .cfg       (cfg_r),
    .pen       (pen_r),
    .char_code (in_char_code),
    .pen_nxt   (pen_step),
    .glyph     (glyph)
  );

  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;

  always_comb begin
    cfg_nxt = cfg_r;
    cfg_hit = 1'b0;
    if (cfg_fire) begin
      unique case (cfg_index)
        REG_ORIGIN_X: begin
          cfg_nxt.origin_x = cfg_data[OX_W-1:0];
          cfg_hit = 1'b1;
        end
        REG_ORIGIN_Y: begin
          cfg_nxt.origin_y = cfg_data[OY_W-1:0];
          cfg_hit = 1'b1;
        end
        REG_BOX_WIDTH: begin
          cfg_nxt.box_width = cfg_data[OX_W-1:0];
          cfg_hit = 1'b1;
        end
        REG_BOX_HEIGHT: begin
          cfg_nxt.box_height = cfg_data[OY_W-1:0];
          cfg_hit = 1'b1;
        end
        default: begin
          cfg_hit = 1'b0;
        end
      endcase
    end

    pen_nxt = pen_r;
    if (cfg_hit) begin
      pen_nxt.pen_x  = PEN_X_W'(cfg_nxt.origin_x);
      pen_nxt.pen_y  = PEN_Y_W'(cfg_nxt.origin_y);
      pen_nxt.halted = 1'b0;
    end else if (in_fire) begin
      if (in_last_char) begin
        pen_nxt.pen_x  = PEN_X_W'(cfg_r.origin_x);
        pen_nxt.pen_y  = PEN_Y_W'(cfg_r.origin_y);
        pen_nxt.halted = 1'b0;
      end else begin
        pen_nxt = pen_step;
      end
    end

    out_valid_nxt = (in_fire && glyph.emit) || (out_valid_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.origin_x   <= RST_ORIGIN_X;
      cfg_r.origin_y   <= RST_ORIGIN_Y;
      cfg_r.box_width  <= RST_BOX_WIDTH;
      cfg_r.box_height <= RST_BOX_HEIGHT;
      pen_r.pen_x      <= PEN_X_W'(RST_ORIGIN_X);
      pen_r.pen_y      <= PEN_Y_W'(RST_ORIGIN_Y);
      pen_r.halted     <= 1'b0;
      out_valid_r      <= 1'b0;
    end else begin
      cfg_r       <= cfg_nxt;
      pen_r       <= pen_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && glyph.emit) begin
      res_r <= glyph;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_glyph_x = res_r.glyph_x;
  assign out_glyph_y = res_r.glyph_y;
  assign out_tex_u   = res_r.tex_u;
  assign out_tex_v   = res_r.tex_v;

endmodule

// ===== verif/dtgl_checker.sv =====
`timescale 1ns / 1ps

module dtgl_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic [dtgl_pkg::CODE_W-1:0]    in_char_code,
  input  logic                           in_last_char,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic [dtgl_pkg::GX_W-1:0]      out_glyph_x,
  input  logic [dtgl_pkg::GY_W-1:0]      out_glyph_y,
  input  logic [dtgl_pkg::TU_W-1:0]      out_tex_u,
  input  logic [dtgl_pkg::TV_W-1:0]      out_tex_v,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [dtgl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dtgl_pkg::CFG_DAT_W-1:0] cfg_data,
  output int                             errors,
  output int                             pending,
  output int                             glyphs
);
  import dtgl_pkg::*;

  typedef struct packed {
    logic [GX_W-1:0] x;
    logic [GY_W-1:0] y;
    logic [TU_W-1:0] u;
    logic [TV_W-1:0] v;
  } glyph_exp_t;

  glyph_exp_t glyph_q[$];

  logic [OX_W-1:0]    org_x;
  logic [OY_W-1:0]    org_y;
  logic [OX_W-1:0]    box_w;
  logic [OY_W-1:0]    box_h;
  logic [PEN_X_W-1:0] pen_x;
  logic [PEN_Y_W-1:0] pen_y;
  logic               halted;

  int err_cnt = 0;
  int glyph_cnt = 0;

  initial begin
    errors = 0;
    pending = 0;
    glyphs = 0;
  end

  task automatic home_pen();
    pen_x = PEN_X_W'(org_x);
    pen_y = PEN_Y_W'(org_y);
    halted = 1'b0;
  endtask

  // pen update for one accepted character; queues a glyph for printable codes
  task automatic place_char(input logic [CODE_W-1:0] code_in, input logic last);
    logic [CODE_W-1:0]  code;
    logic [PEN_X_W-1:0] x_end;
    logic [PEN_Y_W-1:0] y_end;
    logic [5:0]         idx;
    glyph_exp_t         g;
    code = code_in;
    if (!halted) begin
      x_end = PEN_X_W'(org_x) + PEN_X_W'(box_w);
      y_end = PEN_Y_W'(org_y) + PEN_Y_W'(box_h);
      if (code >= CH_LOWER_A && code <= CH_LOWER_Z) code = code - CASE_OFS;
      if (code == CH_SPACE) begin
        pen_x = pen_x + ADV_CHAR;
      end else if (code == CH_TAB) begin
        pen_x = pen_x + ADV_TAB;
      end else if (code == CH_NL) begin
        pen_x = PEN_X_W'(org_x);
        pen_y = pen_y + ADV_LINE;
      end else if (code > CH_SPACE && code <= CH_GLYPH_HI) begin
        idx = 6'(code - CH_SPACE);
        g.x = pen_x[GX_W-1:0];
        g.y = pen_y[GY_W-1:0];
        g.u = {idx[3:0], 3'b000};
        g.v = {idx[5:4], 3'b000};
        glyph_q.push_back(g);
        pen_x = pen_x + ADV_CHAR;
      end
      if (pen_x >= x_end) begin
        pen_x = PEN_X_W'(org_x);
        pen_y = pen_y + ADV_LINE;
      end
      if (pen_y >= y_end) halted = 1'b1;
    end
    if (last) home_pen();
  endtask

  always @(posedge clk) begin
    glyph_exp_t g;
    if (!rst_n) begin
      org_x = RST_ORIGIN_X;
      org_y = RST_ORIGIN_Y;
      box_w = RST_BOX_WIDTH;
      box_h = RST_BOX_HEIGHT;
      home_pen();
      glyph_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        glyph_cnt++;
        if (glyph_q.size() == 0) begin
          if (err_cnt < 10)
            $display("%0t: unexpected glyph x=%0d y=%0d u=%0d v=%0d", $realtime,
                     out_glyph_x, out_glyph_y, out_tex_u, out_tex_v);
          err_cnt++;
        end else begin
          g = glyph_q.pop_front();
          if (g.x !== out_glyph_x || g.y !== out_glyph_y ||
              g.u !== out_tex_u || g.v !== out_tex_v) begin
            if (err_cnt < 10)
              $display({"%0t: glyph mismatch exp x=%0d y=%0d u=%0d v=%0d",
                        " got x=%0d y=%0d u=%0d v=%0d"},
                       $realtime, g.x, g.y, g.u, g.v,
                       out_glyph_x, out_glyph_y, out_tex_u, out_tex_v);
            err_cnt++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ORIGIN_X: begin
            org_x = cfg_data[OX_W-1:0];
            home_pen();
          end
          REG_ORIGIN_Y: begin
            org_y = cfg_data[OY_W-1:0];
            home_pen();
          end
          REG_BOX_WIDTH: begin
            box_w = cfg_data[OX_W-1:0];
            home_pen();
          end
          REG_BOX_HEIGHT: begin
            box_h = cfg_data[OY_W-1:0];
            home_pen();
          end
          default: ;
        endcase
      end
      if (in_valid && in_ready) place_char(in_char_code, in_last_char);
    end
    pending <= glyph_q.size();
    errors  <= err_cnt;
    glyphs  <= glyph_cnt;
  end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import dtgl_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd6;
  localparam int RAND_ITEMS  = 690;
  localparam int BOXES       = 6;
  localparam int HOLD_CYCLES = 80;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [CODE_W-1:0]    in_char_code = '0;
  logic                 in_last_char = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [GX_W-1:0]      out_glyph_x;
  logic [GY_W-1:0]      out_glyph_y;
  logic [TU_W-1:0]      out_tex_u;
  logic [TV_W-1:0]      out_tex_v;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_data = '0;

  int errors;
  int pending;
  int glyphs;

  int send_idle = 14;
  int recv_idle = 46;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int chars_sent = 0;
  int rand_sent = 0;
  int writes = 0;

  logic [CODE_W-1:0] opening [24] = '{
    8'd65, CH_LOWER_A, CH_LOWER_Z, 8'd90, 8'd33, CH_GLYPH_HI, 8'd96, 8'd123,
    8'd255, 8'd128, 8'd127, 8'd0, 8'd31, CH_TAB, CH_NL, CH_SPACE,
    8'd64, 8'd48, 8'd63, CH_NL, 8'd126, 8'd8, 8'd11, 8'd109
  };

  always #4 clk = ~clk;

  debug_text_glyph_layout_top i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_char_code (in_char_code),
    .in_last_char (in_last_char),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_glyph_x  (out_glyph_x),
    .out_glyph_y  (out_glyph_y),
    .out_tex_u    (out_tex_u),
    .out_tex_v    (out_tex_v),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  dtgl_checker i_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_char_code (in_char_code),
    .in_last_char (in_last_char),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_glyph_x  (out_glyph_x),
    .out_glyph_y  (out_glyph_y),
    .out_tex_u    (out_tex_u),
    .out_tex_v    (out_tex_v),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .errors       (errors),
    .pending      (pending),
    .glyphs       (glyphs)
  );

  // glyph sink; a hold request blocks it for a long stretch
  always @(posedge clk) begin
    if (hold_seen != hold_req) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  initial begin
    #2_000_000;
    $display("timeout with %0d glyphs outstanding", pending);
    $display("RESULT: ERROR");
    $finish;
  end

  task automatic send_char(input logic [CODE_W-1:0] code, input logic last);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_char_code <= code;
    in_last_char <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    chars_sent++;
  endtask

  // drain: every queued glyph seen, then room for a trailing ignored character
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    writes++;
  endtask

  task automatic set_box(input logic [CFG_DAT_W-1:0] ox, input logic [CFG_DAT_W-1:0] oy,
                         input logic [CFG_DAT_W-1:0] w, input logic [CFG_DAT_W-1:0] h);
    write_reg(REG_ORIGIN_X, ox);
    write_reg(REG_ORIGIN_Y, oy);
    write_reg(REG_BOX_WIDTH, w);
    write_reg(REG_BOX_HEIGHT, h);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [CODE_W-1:0] pick_char();
    int r;
    r = $urandom_range(99);
    if (r < 60) return CODE_W'($urandom_range(33, 95));
    if (r < 72) return CODE_W'($urandom_range(CH_LOWER_A, CH_LOWER_Z));
    if (r < 78) return CH_SPACE;
    if (r < 82) return CH_TAB;
    if (r < 88) return CH_NL;
    return CODE_W'($urandom_range(255));
  endfunction

  // messages of random text, each closed by a last flag; a few cut short
  task automatic send_text(input int n);
    int left;
    int len;
    logic last;
    left = n;
    while (left > 0) begin
      len = $urandom_range(1, 48);
      if (len > left) len = left;
      for (int k = 0; k < len; k++) begin
        last = (k == len - 1) || ($urandom_range(99) < 3);
        send_char(pick_char(), last);
        rand_sent++;
        if (rand_sent < RAND_ITEMS / 3) begin
          send_idle = 14;
          recv_idle = 46;
        end else if (rand_sent < 2 * RAND_ITEMS / 3) begin
          send_idle = 46;
          recv_idle = 14;
        end else begin
          send_idle = 0;
          recv_idle = 0;
        end
      end
      left -= len;
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (opening[i]) send_char(opening[i], i == 16 || i == 23);
    settle();

    for (int b = 0; b < BOXES; b++) begin
      case (b)
        0: set_box(10'd1023, 10'd511, 10'd1023, 10'd511);
        1: set_box(10'd0, 10'd0, 10'd0, 10'd0);
        2: set_box(CFG_DAT_W'($urandom_range(1023)), CFG_DAT_W'($urandom_range(511)),
                   CFG_DAT_W'($urandom_range(24, 64)), CFG_DAT_W'($urandom_range(16, 40)));
        3: set_box(CFG_DAT_W'($urandom_range(1023)), CFG_DAT_W'($urandom_range(1023)),
                   CFG_DAT_W'($urandom_range(1023)), CFG_DAT_W'($urandom_range(1023)));
        4: set_box(10'd1023, 10'd0, 10'd1023, CFG_DAT_W'($urandom_range(8, 48)));
        default: begin
          write_reg(REG_SPARE, CFG_DAT_W'($urandom_range(1023)));
          set_box(CFG_DAT_W'(RST_ORIGIN_X), CFG_DAT_W'(RST_ORIGIN_Y),
                  CFG_DAT_W'(RST_BOX_WIDTH), CFG_DAT_W'(RST_BOX_HEIGHT));
        end
      endcase
      if (b == 0 || b == 3) hold_req++;
      send_text(RAND_ITEMS / BOXES);
      settle();
    end

    repeat (8) @(posedge clk);
    $display("sent %0d characters (%0d random) over %0d box settings, %0d register writes",
             chars_sent, rand_sent, BOXES + 1, writes);
    $display("checked %0d glyphs with mixed, swapped and no idling plus long sink stalls",
             glyphs);
    if (errors == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
